// ===== hw/rtl/bgd_pkg.sv =====
// Shared types, phase and event codes for the button gesture detector.
// No dependencies; imported by bgd_step, button_gesture_detector_top and tb_top.
`timescale 1ns / 1ps

package bgd_pkg;

  localparam int NumButtons = 8;

  localparam int IdxW     = 3;
  localparam int StampW   = 32;
  localparam int LimitW   = 16;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 16;
  localparam int PhaseW   = 3;
  localparam int KindW    = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDebounce   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgLongPress  = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgDoubleWin  = CfgIdxW'(2);

  localparam logic [LimitW-1:0] DebounceRst   = LimitW'(20);
  localparam logic [LimitW-1:0] LongPressRst  = LimitW'(800);
  localparam logic [LimitW-1:0] DoubleWinRst  = LimitW'(300);

  // Gesture phases
  localparam logic [PhaseW-1:0] PhIdle  = 3'd0;
  localparam logic [PhaseW-1:0] PhDeb   = 3'd1;
  localparam logic [PhaseW-1:0] PhHeld  = 3'd2;
  localparam logic [PhaseW-1:0] PhWait  = 3'd3;
  localparam logic [PhaseW-1:0] PhDeb2  = 3'd4;
  localparam logic [PhaseW-1:0] PhHeld2 = 3'd5;
  localparam logic [PhaseW-1:0] PhLong  = 3'd6;

  // Event kinds
  localparam logic [KindW-1:0] EvLongStart   = 2'd0;
  localparam logic [KindW-1:0] EvShort       = 2'd1;
  localparam logic [KindW-1:0] EvDouble      = 2'd2;
  localparam logic [KindW-1:0] EvLongRelease = 2'd3;

  typedef struct packed {
    logic [IdxW-1:0]   button_index;
    logic              pressed;
    logic [StampW-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0]  event_button;
    logic [KindW-1:0] event_kind;
  } out_item_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [StampW-1:0] press_stamp;
    logic [StampW-1:0] release_stamp;
  } rec_t;

  typedef struct packed {
    logic [LimitW-1:0] debounce_time;
    logic [LimitW-1:0] long_press_time;
    logic [LimitW-1:0] double_window_time;
  } cfg_t;

  typedef struct packed {
    logic             ev_valid;
    logic [KindW-1:0] ev_kind;
  } step_res_t;

endpackage

// ===== hw/rtl/bgd_step.sv =====
// Per-button gesture update: next record and optional event from one poll.
// Depends on bgd_pkg for record, config and result types and codes.
`timescale 1ns / 1ps

module bgd_step import bgd_pkg::*; (
  input  rec_t             cur_i,
  input  logic             pressed_i,
  input  logic [StampW-1:0] now_i,
  input  cfg_t             cfg_i,
  output rec_t             nxt_o,
  output step_res_t        res_o
);

  logic [StampW-1:0] press_el;
  logic [StampW-1:0] release_el;
  logic              deb_done;
  logic              long_done;
  logic              win_done;

  // wrapping elapsed time since each stamp
  assign press_el   = now_i - cur_i.press_stamp;
  assign release_el = now_i - cur_i.release_stamp;
  assign deb_done   = press_el >= {{(StampW-LimitW){1'b0}}, cfg_i.debounce_time};
  assign long_done  = press_el >= {{(StampW-LimitW){1'b0}}, cfg_i.long_press_time};
  assign win_done   = release_el >= {{(StampW-LimitW){1'b0}}, cfg_i.double_window_time};

  always_comb begin
    nxt_o          = cur_i;
    res_o.ev_valid = 1'b0;
    res_o.ev_kind  = EvLongStart;
    unique case (cur_i.phase)
      PhIdle: begin
        if (pressed_i) begin
          nxt_o.phase       = PhDeb;
          nxt_o.press_stamp = now_i;
        end
      end
      PhDeb: begin
        if (deb_done) begin
          if (pressed_i) begin
            nxt_o.phase       = PhHeld;
            nxt_o.press_stamp = now_i;
          end else begin
            nxt_o.phase = PhIdle;
          end
        end
      end
      PhHeld: begin
        if (!pressed_i) begin
          nxt_o.phase         = PhWait;
          nxt_o.release_stamp = now_i;
        end else if (long_done) begin
          nxt_o.phase    = PhLong;
          res_o.ev_valid = 1'b1;
          res_o.ev_kind  = EvLongStart;
        end
      end
      PhWait: begin
        if (pressed_i) begin
          nxt_o.phase       = PhDeb2;
          nxt_o.press_stamp = now_i;
        end else if (win_done) begin
          nxt_o.phase    = PhIdle;
          res_o.ev_valid = 1'b1;
          res_o.ev_kind  = EvShort;
        end
      end
      PhDeb2: begin
        if (deb_done) begin
          if (pressed_i) begin
            nxt_o.phase       = PhHeld2;
            nxt_o.press_stamp = now_i;
          end else begin
            nxt_o.phase         = PhWait;
            nxt_o.release_stamp = now_i;
          end
        end
      end
      PhHeld2: begin
        if (!pressed_i) begin
          nxt_o.phase    = PhIdle;
          res_o.ev_valid = 1'b1;
          res_o.ev_kind  = EvDouble;
        end
      end
      PhLong: begin
        if (!pressed_i) begin
          nxt_o.phase    = PhIdle;
          res_o.ev_valid = 1'b1;
          res_o.ev_kind  = EvLongRelease;
        end
      end
      default: begin
        // unused phase code falls back to idle
        nxt_o.phase = PhIdle;
      end
    endcase
  end

endmodule

// ===== hw/rtl/button_gesture_detector_top.sv =====
// Button gesture detector top level: record memory, pipeline and config registers.
// Depends on bgd_pkg and bgd_step.
`timescale 1ns / 1ps

// Takes one poll item per cycle, except while stalled. Each button's record (phase, press
// stamp, release stamp) lives in a synchronous memory: the read is issued when an
// item is accepted; the update is computed and written back as it leaves stage 1.
// A poll of the same button in the following cycle takes the record from the
// last-write register instead of the memory. Events are held in an output register
// until taken; input is stalled only while a pending event cannot enter a full,
// stalled output register. After reset every record reads as idle with zero
// stamps through per-entry valid bits, so no clearing pass is needed. Polls of
// buttons at or above NUM_BUTTONS are accepted and dropped.
module button_gesture_detector_top import bgd_pkg::*; #(
  parameter int NUM_BUTTONS = NumButtons
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int AddrW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  cfg_t cfg_q;

  rec_t mem_q [NUM_BUTTONS];
  rec_t rd_rec_q;
  logic [NUM_BUTTONS-1:0] ent_vld_q;

  logic             in_acc;
  logic             in_range;
  logic [AddrW+IdxW-1:0] addr_ext;
  logic [AddrW-1:0] rd_addr;

  logic             s1_valid_q;
  in_item_t         s1_item_q;
  logic [AddrW-1:0] s1_addr_q;
  logic             s1_inr_q;
  logic             rd_vld_q;
  logic             s1_fire;

  logic             wr_vld_q;
  logic [AddrW-1:0] wr_addr_q;
  rec_t             wr_rec_q;

  rec_t             cur_rec;
  rec_t             nxt_rec;
  step_res_t        res;
  logic             ev;
  logic             wr_en;

  logic             out_valid_q;
  out_item_t        out_item_q;

  // ---------------- configuration ----------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_time      <= DebounceRst;
      cfg_q.long_press_time    <= LongPressRst;
      cfg_q.double_window_time <= DoubleWinRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgDebounce:  cfg_q.debounce_time      <= cfg_data_i;
        CfgLongPress: cfg_q.long_press_time    <= cfg_data_i;
        CfgDoubleWin: cfg_q.double_window_time <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- stage 0: accept and read ----------------
  assign in_acc   = in_valid_i & ~in_stall_o;
  assign addr_ext = {{AddrW{1'b0}}, in_item_i.button_index};
  assign rd_addr  = addr_ext[AddrW-1:0];
  assign in_range = ({29'd0, in_item_i.button_index} < 32'(NUM_BUTTONS));

  always_ff @(posedge clk_i) begin
    if (in_acc && in_range) begin
      rd_rec_q <= mem_q[rd_addr];
    end
    if (wr_en) begin
      mem_q[s1_addr_q] <= nxt_rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_inr_q   <= 1'b0;
      rd_vld_q   <= 1'b0;
      ent_vld_q  <= '0;
      wr_vld_q   <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        s1_inr_q   <= in_range;
        rd_vld_q   <= in_range & ent_vld_q[rd_addr];
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (wr_en) begin
        ent_vld_q[s1_addr_q] <= 1'b1;
        wr_vld_q             <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_item_i;
      s1_addr_q <= rd_addr;
    end
    if (wr_en) begin
      wr_addr_q <= s1_addr_q;
      wr_rec_q  <= nxt_rec;
    end
  end

  // ---------------- stage 1: modify and write back ----------------
  // forward the last write when it hit the entry just read
  always_comb begin
    if (wr_vld_q && (wr_addr_q == s1_addr_q)) begin
      cur_rec = wr_rec_q;
    end else if (rd_vld_q) begin
      cur_rec = rd_rec_q;
    end else begin
      cur_rec = '0;
    end
  end

  bgd_step u_step (
    .cur_i     (cur_rec),
    .pressed_i (s1_item_q.pressed),
    .now_i     (s1_item_q.now_ms),
    .cfg_i     (cfg_q),
    .nxt_o     (nxt_rec),
    .res_o     (res)
  );

  assign ev         = s1_inr_q & res.ev_valid;
  assign s1_fire    = s1_valid_q & (~ev | ~out_valid_q | ~out_stall_i);
  assign wr_en      = s1_fire & s1_inr_q;
  assign in_stall_o = s1_valid_q & ~s1_fire;

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && ev) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && ev) begin
      out_item_q.event_button <= s1_item_q.button_index;
      out_item_q.event_kind   <= res.ev_kind;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for button_gesture_detector_top: directed polls, then random
// gesture sequences under several timing settings and idling modes. Depends on bgd_pkg.
`timescale 1ns / 1ps

module tb_top;
  import bgd_pkg::*;

  localparam int DrainCycles  = 4;
  localparam int StallLimit   = 5000;
  localparam int RandPerPhase = 205;
  localparam int NumPhases    = 6;
  localparam int ShownErrors  = 10;

  // register indexes the block has no register for
  localparam logic [CfgIdxW-1:0] CfgUnused = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] CfgTopIdx = '1;

  typedef enum logic [1:0] {ChkModel, ChkQuiet, ChkEvent} row_chk_e;

  typedef struct packed {
    logic [IdxW-1:0]   btn;
    logic              down;
    logic [StampW-1:0] at_ms;
    row_chk_e          chk;
    logic [KindW-1:0]  kind;
  } poll_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  in_item_t            in_item_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_item_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  button_gesture_detector_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // gesture predictor: per-button phase and stamps, plus the three limits
  logic [PhaseW-1:0] btn_phase [NumButtons];
  logic [StampW-1:0] press_at  [NumButtons];
  logic [StampW-1:0] release_at[NumButtons];
  logic [LimitW-1:0] deb_lim  = DebounceRst;
  logic [LimitW-1:0] long_lim = LongPressRst;
  logic [LimitW-1:0] win_lim  = DoubleWinRst;

  out_item_t event_q[$];
  int        err_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        quiet_cycles = 0;

  poll_row_t script[27] = '{
    // short press on button 0, reported when the window runs out
    '{3'd0, 1'b1, 32'd1000, ChkQuiet, EvLongStart},
    '{3'd0, 1'b1, 32'd1020, ChkModel, EvLongStart},
    '{3'd0, 1'b0, 32'd1100, ChkModel, EvLongStart},
    '{3'd0, 1'b0, 32'd1400, ChkEvent, EvShort},
    // long press on button 7 from time zero
    '{3'd7, 1'b1, 32'd0,    ChkQuiet, EvLongStart},
    '{3'd7, 1'b1, 32'd20,   ChkModel, EvLongStart},
    '{3'd7, 1'b1, 32'd820,  ChkEvent, EvLongStart},
    '{3'd7, 1'b0, 32'd900,  ChkEvent, EvLongRelease},
    // double click, with a bounce inside the second debounce
    '{3'd3, 1'b1, 32'd5000, ChkQuiet, EvLongStart},
    '{3'd3, 1'b1, 32'd5020, ChkModel, EvLongStart},
    '{3'd3, 1'b0, 32'd5050, ChkModel, EvLongStart},
    '{3'd3, 1'b1, 32'd5100, ChkModel, EvLongStart},
    '{3'd3, 1'b0, 32'd5110, ChkModel, EvLongStart},
    '{3'd3, 1'b1, 32'd5120, ChkModel, EvLongStart},
    '{3'd3, 1'b0, 32'd5130, ChkEvent, EvDouble},
    // second press released at its debounce end: back to waiting, then short
    '{3'd4, 1'b1, 32'd100,  ChkQuiet, EvLongStart},
    '{3'd4, 1'b1, 32'd120,  ChkModel, EvLongStart},
    '{3'd4, 1'b0, 32'd130,  ChkModel, EvLongStart},
    '{3'd4, 1'b1, 32'd140,  ChkModel, EvLongStart},
    '{3'd4, 1'b0, 32'd160,  ChkModel, EvLongStart},
    '{3'd4, 1'b0, 32'd460,  ChkEvent, EvShort},
    // bounce that is released when debounce ends: no event
    '{3'd1, 1'b1, 32'd0,    ChkQuiet, EvLongStart},
    '{3'd1, 1'b0, 32'd25,   ChkQuiet, EvLongStart},
    // long press across the timestamp wrap
    '{3'd2, 1'b1, 32'hFFFF_FFF0, ChkQuiet, EvLongStart},
    '{3'd2, 1'b1, 32'd4,         ChkModel, EvLongStart},
    '{3'd2, 1'b1, 32'd804,       ChkEvent, EvLongStart},
    '{3'd2, 1'b0, 32'hFFFF_FFFF, ChkEvent, EvLongRelease}
  };

  function automatic void next_gesture(input in_item_t it, output bit fired,
                                       output logic [KindW-1:0] kind);
    int unsigned       k;
    logic [StampW-1:0] since_press;
    logic [StampW-1:0] since_release;
    k = it.button_index;
    fired = 1'b0;
    kind = EvLongStart;
    since_press = it.now_ms - press_at[k];
    since_release = it.now_ms - release_at[k];
    case (btn_phase[k])
      PhIdle: begin
        if (it.pressed) begin
          btn_phase[k] = PhDeb;
          press_at[k] = it.now_ms;
        end
      end
      PhDeb: begin
        if (since_press >= deb_lim) begin
          if (it.pressed) begin
            btn_phase[k] = PhHeld;
            press_at[k] = it.now_ms;
          end else begin
            btn_phase[k] = PhIdle;
          end
        end
      end
      PhHeld: begin
        if (!it.pressed) begin
          btn_phase[k] = PhWait;
          release_at[k] = it.now_ms;
        end else if (since_press >= long_lim) begin
          btn_phase[k] = PhLong;
          fired = 1'b1;
          kind = EvLongStart;
        end
      end
      PhWait: begin
        if (it.pressed) begin
          btn_phase[k] = PhDeb2;
          press_at[k] = it.now_ms;
        end else if (since_release >= win_lim) begin
          btn_phase[k] = PhIdle;
          fired = 1'b1;
          kind = EvShort;
        end
      end
      PhDeb2: begin
        if (since_press >= deb_lim) begin
          if (it.pressed) begin
            btn_phase[k] = PhHeld2;
            press_at[k] = it.now_ms;
          end else begin
            btn_phase[k] = PhWait;
            release_at[k] = it.now_ms;
          end
        end
      end
      PhHeld2: begin
        if (!it.pressed) begin
          btn_phase[k] = PhIdle;
          fired = 1'b1;
          kind = EvDouble;
        end
      end
      PhLong: begin
        if (!it.pressed) begin
          btn_phase[k] = PhIdle;
          fired = 1'b1;
          kind = EvLongRelease;
        end
      end
      default: btn_phase[k] = PhIdle;
    endcase
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= ShownErrors) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic set_idling(input int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
      default: begin send_idle_pct = 16; recv_stall_pct = 16; end
    endcase
  endtask

  // drive one poll item, then book its event once the block takes it
  task automatic send_poll(input in_item_t it, input row_chk_e chk,
                           input logic [KindW-1:0] typed_kind);
    bit               fired;
    logic [KindW-1:0] kind;
    out_item_t        ev;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    next_gesture(it, fired, kind);
    ev.event_button = it.button_index;
    case (chk)
      ChkModel: begin
        if (fired) begin
          ev.event_kind = kind;
          event_q.push_back(ev);
        end
      end
      ChkEvent: begin
        ev.event_kind = typed_kind;
        event_q.push_back(ev);
      end
      default: ;
    endcase
  endtask

  // write one register once the block has drained
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    // drop the last item so it is not taken again while draining
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (event_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgDebounce:  deb_lim = val;
      CfgLongPress: long_lim = val;
      CfgDoubleWin: win_lim = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // compare each taken event with the oldest one booked
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (event_q.size() == 0) begin
        flag_error($sformatf("unexpected event button %0d kind %0d",
                             out_item_o.event_button, out_item_o.event_kind));
      end else begin
        want = event_q.pop_front();
        if (out_item_o.event_button !== want.event_button ||
            out_item_o.event_kind !== want.event_kind) begin
          flag_error($sformatf("event mismatch: expected button %0d kind %0d, got %0d/%0d",
                               want.event_button, want.event_kind,
                               out_item_o.event_button, out_item_o.event_kind));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    in_item_t          it;
    logic              lvl      [NumButtons];
    logic [StampW-1:0] btn_clock[NumButtons];
    logic [StampW-1:0] base;
    logic [StampW-1:0] lim;
    logic [StampW-1:0] span;
    int unsigned       b;

    for (int i = 0; i < NumButtons; i++) begin
      btn_phase[i] = PhIdle;
      press_at[i] = '0;
      release_at[i] = '0;
      lvl[i] = 1'b0;
      btn_clock[i] = $urandom;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_idling(0);
    foreach (script[r]) begin
      it.button_index = script[r].btn;
      it.pressed = script[r].down;
      it.now_ms = script[r].at_ms;
      send_poll(it, script[r].chk, script[r].kind);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        1: begin
          write_reg(CfgDebounce, '0);
          write_reg(CfgLongPress, '0);
          write_reg(CfgDoubleWin, '0);
        end
        2: begin
          write_reg(CfgDebounce, '1);
          write_reg(CfgLongPress, '1);
          write_reg(CfgDoubleWin, '1);
        end
        3: begin
          write_reg(CfgDebounce, CfgDataW'($urandom_range(0, 40)));
          write_reg(CfgLongPress, CfgDataW'($urandom_range(0, 200)));
          write_reg(CfgDoubleWin, CfgDataW'($urandom_range(0, 200)));
        end
        4: begin
          write_reg(CfgDebounce, CfgDataW'(1));
          write_reg(CfgLongPress, '1);
          write_reg(CfgDoubleWin, '0);
          write_reg(CfgUnused, CfgDataW'($urandom));
          write_reg(CfgTopIdx, CfgDataW'($urandom));
        end
        5: begin
          write_reg(CfgDebounce, DebounceRst);
          write_reg(CfgLongPress, LongPressRst);
          write_reg(CfgDoubleWin, DoubleWinRst);
        end
        default: ;
      endcase

      for (int n = 0; n < RandPerPhase; n++) begin
        if (n == 0) set_idling(2 * ph);
        if (n == RandPerPhase / 2) set_idling(2 * ph + 1);
        b = $urandom_range(0, NumButtons - 1);
        if ($urandom_range(0, 99) < 30) lvl[b] = ~lvl[b];
        it.button_index = IdxW'(b);
        it.pressed = lvl[b];
        if ($urandom_range(0, 99) < 10) it.pressed = 1'($urandom_range(0, 1));

        // aim the timestamp at the limit that matters in this button's phase
        case (btn_phase[b])
          PhDeb, PhDeb2: begin base = press_at[b];   lim = deb_lim;  end
          PhHeld:        begin base = press_at[b];   lim = long_lim; end
          PhWait:        begin base = release_at[b]; lim = win_lim;  end
          default:       begin base = btn_clock[b];  lim = 50;       end
        endcase
        case ($urandom_range(0, 9))
          0, 1, 2: span = $urandom_range(0, lim >> 1);
          3:       span = lim - 1;
          4, 5:    span = lim;
          6:       span = lim + 1;
          7, 8:    span = $urandom_range(0, 2 * lim + 2);
          default: span = $urandom;
        endcase
        btn_clock[b] = base + span;
        it.now_ms = btn_clock[b];
        send_poll(it, ChkModel, EvLongStart);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (event_q.size() != 0) @(posedge clk_i);
    repeat (2 * DrainCycles) @(posedge clk_i);
    if (event_q.size() != 0) flag_error("events still outstanding at end of run");
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bgd_pkg.sv
hw/rtl/bgd_step.sv
hw/rtl/button_gesture_detector_top.sv
tb/tb_top.sv
